[design/assert_macros.svh]
// assert_macros.svh: assertion macros for checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on clk, disabled while in reset.
`define FFPA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property that must also hold during reset.
`define FFPA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ffpa_pkg.sv]
// ffpa_pkg: shared types and constants for the first fit partition allocator.
// No dependencies.
package ffpa_pkg;
	localparam int MAX_PARTS_DEF = 128;
	localparam int SIZE_W = 24;
	localparam int OWNER_W = 16;
	localparam int INDEX_W = 7;
	localparam int COUNT_W = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [SIZE_W-1:0] TOTAL_SIZE_RST = 24'd1048576;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'd1;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0] size;
		logic used;
	} entry_t;
endpackage

[design/ffpa_table.sv]
// ffpa_table: partition table memory, one write and one registered read port.
// Depends on ffpa_pkg.
module ffpa_table #(
	parameter int MAX_PARTS = ffpa_pkg::MAX_PARTS_DEF,
	localparam int AW = $clog2(MAX_PARTS)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ffpa_pkg::entry_t      wdata,
	input  logic [AW-1:0]         raddr,
	output ffpa_pkg::entry_t      rdata
);
	ffpa_pkg::entry_t mem [MAX_PARTS];

	// Write and read synchronously; read returns old data on collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/ffpa_ctrl.sv]
// ffpa_ctrl: sequencer that scans, shifts and updates the partition table.
// Depends on ffpa_pkg.
module ffpa_ctrl #(
	parameter int MAX_PARTS = ffpa_pkg::MAX_PARTS_DEF,
	localparam int AW = $clog2(MAX_PARTS),
	localparam int CW = $clog2(MAX_PARTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          in_action,
	input  logic [ffpa_pkg::OWNER_W-1:0]  in_pid,
	input  logic [ffpa_pkg::SIZE_W-1:0]   in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffpa_pkg::STATUS_W-1:0] out_status,
	output logic [ffpa_pkg::INDEX_W-1:0]  out_index,
	output logic [ffpa_pkg::COUNT_W-1:0]  out_count,
	output logic                          we,
	output logic [AW-1:0]                 waddr,
	output ffpa_pkg::entry_t              wdata,
	output logic [AW-1:0]                 raddr,
	input  ffpa_pkg::entry_t              rdata
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_SHR   = 10'b0000000100,
		S_SPLIT = 10'b0000001000,
		S_PREV  = 10'b0000010000,
		S_NEXT  = 10'b0000100000,
		S_FIX   = 10'b0001000000,
		S_SHL   = 10'b0010000000,
		S_DONE  = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic mode_q;
	logic [ffpa_pkg::SIZE_W-1:0] total_q;
	logic [CW-1:0] count_q;
	// Entry 0 is held outside memory validity: entries >= count are never used.
	logic zero_wr_q;
	logic action_q;
	logic [ffpa_pkg::OWNER_W-1:0] pid_q;
	logic [ffpa_pkg::SIZE_W-1:0] req_q;
	logic [AW-1:0] ptr_q;       // address of the entry now on the read data
	logic [AW-1:0] hit_q;       // matched entry
	logic [AW-1:0] tgt_q;       // unused
	logic rd_pend_q;
	ffpa_pkg::entry_t hit_e_q;
	ffpa_pkg::entry_t prev_e_q;
	logic [ffpa_pkg::SIZE_W-1:0] msize_q;
	logic [AW-1:0] mbase_q;     // merged entry position
	logic [1:0] drop_q;         // entries removed by merge
	logic [ffpa_pkg::STATUS_W-1:0] st_q;
	logic [ffpa_pkg::INDEX_W-1:0] idx_q;
	logic ovalid_q;
	logic [ffpa_pkg::STATUS_W-1:0] ostat_q;
	logic [ffpa_pkg::INDEX_W-1:0] oidx_q;
	logic [ffpa_pkg::COUNT_W-1:0] ocount_q;
	logic [AW-1:0] rptr;

	ffpa_pkg::entry_t rd_e;
	logic match;
	logic [ffpa_pkg::SIZE_W:0] sum;

	// Entry 0 reads its rebuilt value until the memory is written after rebuild.
	always_comb begin
		rd_e = rdata;
		if (zero_wr_q && ptr_q == '0) begin
			rd_e = '{owner: '0, size: total_q, used: 1'b0};
		end
	end

	always_comb begin
		if (action_q == ffpa_pkg::ACT_FREE) begin
			match = rd_e.used && rd_e.owner == pid_q;
		end else if (!mode_q) begin
			match = !rd_e.used && rd_e.size == req_q;
		end else begin
			match = !rd_e.used && rd_e.size >= req_q;
		end
	end

	assign sum = {1'b0, msize_q} + {1'b0, rd_e.size};
	assign raddr = rptr;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = ovalid_q;
	assign out_status = ostat_q;
	assign out_index = oidx_q;
	assign out_count = ocount_q;

	// Drive memory read address and write port from the current step.
	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = rd_e;
		rptr = ptr_q;
		unique case (state_q)
			S_IDLE: rptr = '0;
			S_SCAN: begin
				rptr = ptr_q + AW'(1);
				// fetch the left neighbor when a dynamic free hits past entry 0
				if (match && action_q == ffpa_pkg::ACT_FREE && mode_q && ptr_q != '0) begin
					rptr = ptr_q - AW'(1);
				end
			end
			S_SHR: begin
				// move entry ptr to ptr+1, then read ptr-1
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = ptr_q + AW'(1);
					rptr = ptr_q - AW'(1);
				end else begin
					rptr = ptr_q;
				end
			end
			S_SPLIT: begin
				we = 1'b1;
				waddr = hit_q;
				wdata = '{owner: pid_q, size: req_q, used: 1'b1};
			end
			S_PREV: rptr = hit_q + AW'(1);
			S_NEXT: rptr = hit_q + AW'(1);
			S_FIX: begin
				we = 1'b1;
				waddr = mbase_q;
				wdata = '{owner: hit_e_q.owner, size: msize_q, used: 1'b0};
				rptr = mbase_q + AW'(32'(drop_q) + 1);
			end
			S_SHL: begin
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = ptr_q - AW'(drop_q);
					rptr = ptr_q + AW'(1);
				end else begin
					rptr = ptr_q;
				end
			end
			S_DONE, S_WAIT: rptr = ptr_q;
			default: rptr = ptr_q;
		endcase
	end

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 1'b1;
			total_q <= ffpa_pkg::TOTAL_SIZE_RST;
			count_q <= CW'(1);
			zero_wr_q <= 1'b1;
			ovalid_q <= 1'b0;
			ostat_q <= '0;
			oidx_q <= '0;
			ocount_q <= '0;
			ptr_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall && state_q != S_WAIT) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_idx == ffpa_pkg::REG_MODE) begin
					mode_q <= cfg_data[0];
				end else begin
					total_q <= cfg_data[ffpa_pkg::SIZE_W-1:0];
					count_q <= CW'(1);
					zero_wr_q <= 1'b1;
				end
			end
			if (we && waddr == '0) begin
				zero_wr_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					if (in_valid && !in_stall) begin
						action_q <= in_action;
						pid_q <= in_pid;
						req_q <= in_req;
						st_q <= ffpa_pkg::ST_MISS;
						idx_q <= '0;
						if (in_action == ffpa_pkg::ACT_ALLOC && in_req == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					ptr_q <= ptr_q + AW'(1);
					if (match) begin
						hit_q <= ptr_q;
						hit_e_q <= rd_e;
						if (action_q == ffpa_pkg::ACT_ALLOC) begin
							if (mode_q && rd_e.size != req_q) begin
								if (count_q >= CW'(MAX_PARTS)) begin
									st_q <= ffpa_pkg::ST_FULL;
									state_q <= S_DONE;
								end else begin
									// shift entries count-1 down to hit+1 up by one
									ptr_q <= AW'(count_q - CW'(1));
									rd_pend_q <= 1'b0;
									state_q <= S_SHR;
								end
							end else begin
								st_q <= ffpa_pkg::ST_OK;
								idx_q <= ffpa_pkg::INDEX_W'(ptr_q);
								state_q <= S_SPLIT;
							end
						end else begin
							st_q <= ffpa_pkg::ST_OK;
							msize_q <= rd_e.size;
							mbase_q <= ptr_q;
							drop_q <= '0;
							if (!mode_q) begin
								idx_q <= ffpa_pkg::INDEX_W'(ptr_q);
								state_q <= S_FIX;
							end else if (ptr_q != '0) begin
								ptr_q <= ptr_q - AW'(1);
								state_q <= S_PREV;
							end else begin
								ptr_q <= ptr_q + AW'(1);
								state_q <= S_NEXT;
							end
						end
					end else if (CW'(ptr_q) + CW'(1) >= count_q) begin
						state_q <= S_DONE;
					end
				end
				S_SHR: begin
					// S_SHR first cycle has no data yet: ptr set, read issued
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
						ptr_q <= ptr_q;
					end else if (ptr_q == hit_q + AW'(1) || ptr_q == hit_q) begin
						state_q <= S_SPLIT;
						rd_pend_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_SPLIT: begin
					// remainder goes to hit+1
					if (action_q == ffpa_pkg::ACT_ALLOC && mode_q &&
							hit_e_q.size != req_q) begin
						count_q <= count_q + CW'(1);
						msize_q <= hit_e_q.size - req_q;
						mbase_q <= hit_q + AW'(1);
						drop_q <= '0;
						hit_e_q.owner <= '0;
						st_q <= ffpa_pkg::ST_OK;
						idx_q <= ffpa_pkg::INDEX_W'(hit_q);
						state_q <= S_FIX;
						ptr_q <= hit_q;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PREV: begin
					// rd_e is entry hit-1
					if (!rd_e.used) begin
						msize_q <= sum[ffpa_pkg::SIZE_W] ? '1 : sum[ffpa_pkg::SIZE_W-1:0];
						mbase_q <= hit_q - AW'(1);
						drop_q <= 2'd1;
					end
					ptr_q <= hit_q + AW'(1);
					if (CW'(hit_q) + CW'(1) >= count_q) begin
						state_q <= S_FIX;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// rd_e is entry hit+1, valid when hit+1 < count
					if (CW'(hit_q) + CW'(1) < count_q && !rd_e.used) begin
						msize_q <= sum[ffpa_pkg::SIZE_W] ? '1 : sum[ffpa_pkg::SIZE_W-1:0];
						drop_q <= drop_q + 2'd1;
					end
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (action_q == ffpa_pkg::ACT_FREE) begin
						idx_q <= ffpa_pkg::INDEX_W'(mbase_q);
					end
					ptr_q <= mbase_q + AW'(32'(drop_q) + 1);
					rd_pend_q <= 1'b0;
					if (drop_q == '0 ||
							CW'(mbase_q) + CW'(drop_q) + CW'(1) >= count_q) begin
						count_q <= count_q - CW'(drop_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHL;
					end
				end
				S_SHL: begin
					// move entry ptr down by drop
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (CW'(ptr_q) + CW'(1) >= count_q) begin
						count_q <= count_q - CW'(drop_q);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DONE: state_q <= S_WAIT;
				S_WAIT: begin
					// hold the result until the output register is free
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						ostat_q <= st_q;
						oidx_q <= idx_q;
						ocount_q <= ffpa_pkg::COUNT_W'(count_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[design/first_fit_partition_allocator_top.sv]
// An allocate or free takes one pass over the table in address order, one entry per
// cycle from a table memory with one registered read port and one write port;
// the scan stops at the hit and a split or merge then shifts the later entries up one
// place or down by the entries it drops, one entry per cycle. One request runs at a
// time; the next is taken once the previous result sits in the output register.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_table.
module first_fit_partition_allocator_top #(
	parameter int MAX_PARTS = ffpa_pkg::MAX_PARTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [ffpa_pkg::OWNER_W-1:0]    process_id,
	input  logic [ffpa_pkg::SIZE_W-1:0]     request_size,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ffpa_pkg::STATUS_W-1:0]   status,
	output logic [ffpa_pkg::INDEX_W-1:0]    entry_index,
	output logic [ffpa_pkg::COUNT_W-1:0]    entry_count
);
	localparam int AW = $clog2(MAX_PARTS);

	logic we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	ffpa_pkg::entry_t wdata;
	ffpa_pkg::entry_t rdata;

	ffpa_ctrl #(.MAX_PARTS(MAX_PARTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_action(action), .in_pid(process_id), .in_req(request_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_status(status), .out_index(entry_index), .out_count(entry_count),
		.we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	ffpa_table #(.MAX_PARTS(MAX_PARTS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
endmodule

[design/ffpa_checker.sv]
// ffpa_checker: port-level checks for the allocator, bound to the top level.
// Depends on ffpa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffpa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [ffpa_pkg::STATUS_W-1:0] status,
	input logic [ffpa_pkg::INDEX_W-1:0] entry_index,
	input logic [ffpa_pkg::COUNT_W-1:0] entry_count
);
	`FFPA_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "accept not followed by stall")
	`FFPA_ASSERT(a_status_code, clk, arst_n, out_valid |-> (status != 2'd3), "bad status")
	`FFPA_ASSERT(a_fail_index, clk, arst_n, (out_valid && status != ffpa_pkg::ST_OK) |-> (entry_index == '0), "failure with index")
	`FFPA_ASSERT(a_count_nonzero, clk, arst_n, out_valid |-> (entry_count != '0), "empty table")
	`FFPA_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(status)), "stalled beat changed")
endmodule

bind first_fit_partition_allocator_top ffpa_checker u_ffpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.entry_index(entry_index), .entry_count(entry_count)
);

[tb/tb.sv]
// tb: self-checking testbench for first_fit_partition_allocator_top.
// Holds a table predictor, a queued driver and a monitor; depends on ffpa_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffpa_pkg::*;

	localparam int TBL_DEPTH = MAX_PARTS_DEF;
	localparam int END_WAIT = 2 * TBL_DEPTH + 16;

	typedef struct {
		logic action;
		logic [OWNER_W-1:0] pid;
		logic [SIZE_W-1:0] req;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_ALLOC;
	logic [OWNER_W-1:0] process_id = '0;
	logic [SIZE_W-1:0] request_size = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0] entry_index;
	logic [COUNT_W-1:0] entry_count;

	first_fit_partition_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .process_id(process_id), .request_size(request_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .entry_index(entry_index), .entry_count(entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted partition table
	logic [OWNER_W-1:0] tbl_owner [TBL_DEPTH];
	logic [SIZE_W-1:0] tbl_size [TBL_DEPTH];
	logic tbl_used [TBL_DEPTH];
	int tbl_count;
	logic tbl_dynamic;
	logic [SIZE_W-1:0] tbl_total;

	request_t pending_requests[$];
	outcome_t expected_results[$];
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int n_beats = 0;
	int n_ok = 0, n_miss = 0, n_full = 0;

	function automatic void rebuild_table();
		for (int k = 0; k < TBL_DEPTH; k++) begin
			tbl_owner[k] = '0;
			tbl_size[k] = '0;
			tbl_used[k] = 1'b0;
		end
		tbl_size[0] = tbl_total;
		tbl_count = 1;
	endfunction

	// Close the gap left by entry k
	function automatic void remove_entry(int k);
		for (int j = k; j + 1 < tbl_count; j++) begin
			tbl_owner[j] = tbl_owner[j + 1];
			tbl_size[j] = tbl_size[j + 1];
			tbl_used[j] = tbl_used[j + 1];
		end
		tbl_count--;
	endfunction

	function automatic logic [SIZE_W-1:0] sum_sat(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = a + b;
		return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
	endfunction

	// Apply one allocate or free to the predicted table and return its outcome
	function automatic outcome_t predict_table_op(request_t r);
		outcome_t o;
		int i;
		o.status = ST_MISS;
		o.index = '0;
		if (r.action == ACT_ALLOC) begin
			if (r.req != 0) begin
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_used[i]) continue;
					if (!tbl_dynamic) begin
						if (tbl_size[i] != r.req) continue;
					end else begin
						if (tbl_size[i] < r.req) continue;
						if (tbl_size[i] > r.req) begin
							if (tbl_count >= TBL_DEPTH) begin
								o.status = ST_FULL;
								break;
							end
							for (int j = tbl_count; j > i + 1; j--) begin
								tbl_owner[j] = tbl_owner[j - 1];
								tbl_size[j] = tbl_size[j - 1];
								tbl_used[j] = tbl_used[j - 1];
							end
							tbl_owner[i + 1] = '0;
							tbl_size[i + 1] = tbl_size[i] - r.req;
							tbl_used[i + 1] = 1'b0;
							tbl_size[i] = r.req;
							tbl_count++;
						end
					end
					tbl_owner[i] = r.pid;
					tbl_used[i] = 1'b1;
					o.status = ST_OK;
					o.index = i[INDEX_W-1:0];
					break;
				end
			end
		end else begin
			for (i = 0; i < tbl_count; i++) begin
				if (!tbl_used[i] || tbl_owner[i] != r.pid) continue;
				tbl_used[i] = 1'b0;
				if (tbl_dynamic) begin
					if (i > 0 && !tbl_used[i - 1]) begin
						tbl_size[i - 1] = sum_sat(tbl_size[i - 1], tbl_size[i]);
						remove_entry(i);
						i--;
					end
					if (i + 1 < tbl_count && !tbl_used[i + 1]) begin
						tbl_size[i] = sum_sat(tbl_size[i], tbl_size[i + 1]);
						remove_entry(i + 1);
					end
				end
				o.status = ST_OK;
				o.index = i[INDEX_W-1:0];
				break;
			end
		end
		o.count = tbl_count[COUNT_W-1:0];
		return o;
	endfunction

	// Driver: predict each accepted beat, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				r.action = action;
				r.pid = process_id;
				r.req = request_size;
				expected_results.push_back(predict_table_op(r));
			end
			if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				r = pending_requests.pop_front();
				in_valid <= 1'b1;
				action <= r.action;
				process_id <= r.pid;
				request_size <= r.req;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall at random and compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				n_beats++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: status=%0d index=%0d count=%0d",
							status, entry_index, entry_count);
				end else begin
					e = expected_results.pop_front();
					case (e.status)
						ST_OK: n_ok++;
						ST_FULL: n_full++;
						default: n_miss++;
					endcase
					if (status !== e.status || entry_index !== e.index ||
							entry_count !== e.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp status=%0d index=%0d count=%0d, got %0d %0d %0d",
								e.status, e.index, e.count, status, entry_index, entry_count);
					end
				end
			end
		end
	end

	task automatic push_req(logic act, logic [OWNER_W-1:0] pid, logic [SIZE_W-1:0] req);
		request_t r;
		r.action = act;
		r.pid = pid;
		r.req = req;
		pending_requests.push_back(r);
	endtask

	// Mostly a small owner pool and small sizes so frees hit; some wide values
	task automatic push_random(int n, int max_sz);
		int p;
		logic [OWNER_W-1:0] pid;
		logic [SIZE_W-1:0] sz;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(99);
			pid = (p < 90) ? OWNER_W'($urandom_range(7)) : OWNER_W'($urandom);
			p = $urandom_range(99);
			if (p < 85) sz = SIZE_W'($urandom_range(max_sz, 1));
			else if (p < 90) sz = '0;
			else sz = SIZE_W'($urandom);
			push_req(($urandom_range(99) < 45) ? ACT_FREE : ACT_ALLOC, pid, sz);
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// Write one register at an edge and mirror it in the predictor
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_MODE) begin
			tbl_dynamic = val[0];
		end else begin
			tbl_total = val[SIZE_W-1:0];
			rebuild_table();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		wait_idle();
		sender_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		tbl_dynamic = 1'b1;
		tbl_total = TOTAL_SIZE_RST;
		rebuild_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset table, zero and oversize requests, merges, unknown owner
		push_req(ACT_ALLOC, 16'd1, '0);
		push_req(ACT_ALLOC, 16'd1, 24'd1048577);
		push_req(ACT_ALLOC, 16'd1, 24'hFFFFFF);
		push_req(ACT_ALLOC, 16'hFFFF, 24'd100);
		push_req(ACT_ALLOC, 16'd0, 24'd200);
		push_req(ACT_ALLOC, 16'd2, 24'd300);
		push_req(ACT_FREE, 16'd5, 24'hFFFFFF);
		push_req(ACT_FREE, 16'hFFFF, '0);
		push_req(ACT_FREE, 16'd2, '0);
		push_req(ACT_FREE, 16'd0, '0);
		push_req(ACT_ALLOC, 16'd3, 24'd1048576);
		push_req(ACT_FREE, 16'd3, '0);
		push_req(ACT_FREE, 16'd3, '0);
		push_req(ACT_ALLOC, 16'hAAAA, 24'h555555);
		push_req(ACT_ALLOC, 16'h5555, 24'hAAAAAA);

		// Fill the table with unit allocations until it reports full
		write_reg(REG_TOTAL, 24'd300);
		set_idling(64, 0);
		for (int k = 0; k < 130; k++)
			push_req(ACT_ALLOC, OWNER_W'(k % 8), 24'd1);
		push_random(60, 4);

		// Fixed mode keeps the carved table; frees never merge
		write_reg(REG_MODE, 24'd0);
		set_idling(0, 64);
		push_random(80, 4);

		// Widest memory, dynamic
		write_reg(REG_MODE, 24'd1);
		write_reg(REG_TOTAL, 24'hFFFFFF);
		set_idling(15, 15);
		push_random(90, 4096);

		// Empty memory, then a single unit in fixed mode
		write_reg(REG_TOTAL, 24'd0);
		push_req(ACT_ALLOC, 16'd1, 24'd1);
		push_req(ACT_FREE, 16'd1, '0);
		write_reg(REG_MODE, 24'd0);
		write_reg(REG_TOTAL, 24'd1);
		push_req(ACT_ALLOC, 16'd9, 24'd1);
		push_req(ACT_ALLOC, 16'd9, 24'd1);
		push_req(ACT_FREE, 16'd9, '0);

		// Small dynamic memory, no idling
		write_reg(REG_MODE, 24'd1);
		write_reg(REG_TOTAL, 24'd64);
		set_idling(0, 0);
		push_random(100, 8);

		wait_idle();
		repeat (END_WAIT) @(posedge clk);
		$display("%0d result beats checked: %0d ok, %0d not found, %0d table full",
			n_beats, n_ok, n_miss, n_full);
		$display("covered fixed and dynamic modes, sizes 0 to max, four idling mixes");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/ffpa_pkg.sv
design/ffpa_table.sv
design/ffpa_ctrl.sv
design/first_fit_partition_allocator_top.sv
design/ffpa_checker.sv
tb/tb.sv
